// ===== rtl/lruc_pkg.sv =====
// Shared constants, types and coordinate helpers for the LRU block cache.
// No dependencies; lruc_if and the cache unit take names from here by scope.
`default_nettype none
package lruc_pkg;

  localparam int SLOTS   = 16;
  localparam int BLOCKS  = 512;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int BLK_W   = $clog2(BLOCKS);
  localparam int MAP_W   = SLOT_W + 1;
  localparam int CLR_W   = $clog2(BLOCKS + 1);
  localparam int ADDR_W  = 16;
  localparam int OFS_W   = 7;
  localparam int X_W     = 9;
  localparam int Y_W     = 8;

  localparam int HBAR_BLOCKS = 240;

  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef logic [BLK_W-1:0]  blk_t;

  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
  } xy_t;

  // Screen position of a block in the border layout.
  // Top/bottom bars: 40 blocks per row. Side bars: 24 blocks per column.
  function automatic xy_t block_xy(input blk_t blk);
    xy_t        res;
    logic [7:0]  hv;
    logic [15:0] hp;
    logic [2:0]  hq;
    logic [7:0]  hr;
    logic [8:0]  vv;
    logic [17:0] vp;
    logic [3:0]  vq;
    logic [8:0]  vr;
    res = '0;
    hv  = blk[7:0];
    hp  = 16'(hv) * 16'd205;
    hq  = hp[15:13];
    hr  = hv - 8'(8'(hq) * 8'd40);
    vv  = blk - 9'(HBAR_BLOCKS);
    vp  = 18'(vv) * 18'd683;
    vq  = vp[17:14];
    vr  = vv - 9'(9'(vq) * 9'd24);
    if (blk < 9'(HBAR_BLOCKS)) begin
      res.x = {hr[5:0], 3'b000};
      res.y = {2'b00, hq, 3'b000} + ((hq >= 3'd3) ? 8'd192 : 8'd0);
    end else begin
      res.y = {vr[4:0], 3'b000} + 8'd24;
      res.x = {2'b00, vq, 3'b000} + ((vq >= 4'd2) ? 9'd288 : 9'd0);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lruc_if.sv =====
// Valid/ready channel interfaces for access words and result words.
// Depends on lruc_pkg for field widths.
`default_nettype none
interface lruc_in_if;
  logic                        valid;
  logic                        ready;
  logic [lruc_pkg::ADDR_W-1:0] address;
  logic                        is_write;
  modport source (output valid, output address, output is_write, input ready);
  modport sink   (input valid, input address, input is_write, output ready);
endinterface

interface lruc_out_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [3:0]                 slot;
  logic [lruc_pkg::OFS_W-1:0] offset;
  logic                       write_back;
  logic [lruc_pkg::X_W-1:0]   evict_x;
  logic [lruc_pkg::Y_W-1:0]   evict_y;
  logic [lruc_pkg::X_W-1:0]   fill_x;
  logic [lruc_pkg::Y_W-1:0]   fill_y;
  modport source (output valid, output hit, output slot, output offset,
                  output write_back, output evict_x, output evict_y,
                  output fill_x, output fill_y, input ready);
  modport sink   (input valid, input hit, input slot, input offset,
                  input write_back, input evict_x, input evict_y,
                  input fill_x, input fill_y, output ready);
endinterface
`default_nettype wire

// ===== rtl/lruc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; sized by its WIDTH and DEPTH parameters.
`default_nettype none
module lruc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lru_block_cache_screen_border_unit.sv =====
// Fully associative LRU write-back block cache with border-screen coordinates.
// Depends on lruc_pkg, lruc_if (channel interfaces) and lruc_ram (block map).
//
// Usage:
//   in_ch carries access words (address, is_write); out_ch carries one result
//   word per access (hit, slot, offset, write_back, evict and fill coords).
//   Both are valid/ready; a word moves when valid and ready are high at a
//   rising clk edge.
// Path: an accepted access is registered in the lookup stage, then its result
//   in the result register. Throughput: one access per cycle while out_ch.ready
//   is high. The block map read is issued at accept and its registered data
//   feeds the lookup and LRU update; a map write from the previous access is
//   forwarded, so back-to-back accesses to the same block see it.
// Reset (rst_n low, synchronous): slots i hold blocks i, clean, slot 0 is
//   least recently used. After reset a clearing pass writes all 512 block
//   map entries, one entry a cycle; in_ch.ready stays low meanwhile.
// Stall: when out_ch.ready is low the result word holds, the lookup stage
//   holds its access, and in_ch.ready drops once both are occupied.
// Hit check: a map entry is trusted only if the slot it names still holds
//   that block, so eviction never has to scrub the old block's entry.
`default_nettype none
module lru_block_cache_screen_border_unit (
  input wire logic  clk,
  input wire logic  rst_n,
  lruc_in_if.sink   in_ch,
  lruc_out_if.source out_ch
);

  localparam int SLOTS  = lruc_pkg::SLOTS;
  localparam int SLOT_W = lruc_pkg::SLOT_W;
  localparam int BLK_W  = lruc_pkg::BLK_W;
  localparam int MAP_W  = lruc_pkg::MAP_W;
  localparam int CLR_W  = lruc_pkg::CLR_W;

  // Clearing pass
  logic [CLR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             clr_busy;

  // Lookup stage
  logic                 b_valid_r;
  logic [15:0]          b_addr_r;
  logic                 b_wr_r;
  logic                 b_adv;
  lruc_pkg::blk_t       b_blk;

  // Slot state
  lruc_pkg::blk_t       slot_block_r [SLOTS];
  logic                 slot_dirty_r [SLOTS];
  lruc_pkg::slot_idx_t  slot_age_r   [SLOTS];
  lruc_pkg::blk_t       slot_block_nxt [SLOTS];
  logic                 slot_dirty_nxt [SLOTS];
  lruc_pkg::slot_idx_t  slot_age_nxt   [SLOTS];

  // Map write forwarding
  logic                 fwd_valid_r;
  lruc_pkg::blk_t       fwd_blk_r;
  lruc_pkg::slot_idx_t  fwd_idx_r;

  // Map RAM
  logic                 map_we;
  lruc_pkg::blk_t       map_waddr;
  logic [MAP_W-1:0]     map_wdata;
  logic [MAP_W-1:0]     map_rdata;
  logic [MAP_W-1:0]     map_entry;

  // Lookup results
  logic                 hit;
  lruc_pkg::slot_idx_t  lru_slot;
  lruc_pkg::slot_idx_t  sel_slot;
  lruc_pkg::slot_idx_t  sel_age;
  lruc_pkg::blk_t       lru_blk;
  logic                 lru_dirty;
  lruc_pkg::xy_t        evict_xy;
  lruc_pkg::xy_t        fill_xy;

  // Result register
  logic                 out_valid_r;
  logic                 hit_r;
  logic [3:0]           slot_r;
  logic [6:0]           offset_r;
  logic                 write_back_r;
  logic [8:0]           evict_x_r;
  logic [7:0]           evict_y_r;
  logic [8:0]           fill_x_r;
  logic [7:0]           fill_y_r;

  logic                 in_accept;

  assign clr_busy    = (clr_cnt_r != CLR_W'(lruc_pkg::BLOCKS));
  assign clr_cnt_nxt = clr_cnt_r + CLR_W'(1);

  assign b_adv       = b_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !clr_busy && (!b_valid_r || b_adv);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign b_blk       = b_addr_r[15:7];

  // Map write: clearing pass, else a miss loads the new block.
  always_comb begin
    if (clr_busy) begin
      map_we    = 1'b1;
      map_waddr = clr_cnt_r[BLK_W-1:0];
      map_wdata = {(clr_cnt_r < CLR_W'(SLOTS)), clr_cnt_r[SLOT_W-1:0]};
    end else begin
      map_we    = b_adv && !hit;
      map_waddr = b_blk;
      map_wdata = {1'b1, lru_slot};
    end
  end

  lruc_ram #(
    .WIDTH (MAP_W),
    .DEPTH (lruc_pkg::BLOCKS)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (in_accept),
    .raddr (in_ch.address[15:7]),
    .rdata (map_rdata)
  );

  // Take the latest map write when it targets this block.
  assign map_entry = (fwd_valid_r && (fwd_blk_r == b_blk)) ? {1'b1, fwd_idx_r}
                                                           : map_rdata;

  // Lookup, victim choice and LRU update.
  always_comb begin
    logic match;
    match     = 1'b0;
    lru_slot  = '0;
    lru_blk   = '0;
    lru_dirty = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if ((map_entry[SLOT_W-1:0] == SLOT_W'(i)) && (slot_block_r[i] == b_blk)) begin
        match = 1'b1;
      end
      if (slot_age_r[i] == '0) begin
        lru_slot = lru_slot | SLOT_W'(i);
      end
    end
    hit = map_entry[SLOT_W] && match;
    for (int i = 0; i < SLOTS; i++) begin
      if (lru_slot == SLOT_W'(i)) begin
        lru_blk   = slot_block_r[i];
        lru_dirty = slot_dirty_r[i];
      end
    end
    sel_slot = hit ? map_entry[SLOT_W-1:0] : lru_slot;
    sel_age  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (sel_slot == SLOT_W'(i)) begin
        sel_age = slot_age_r[i];
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      slot_block_nxt[i] = slot_block_r[i];
      slot_dirty_nxt[i] = slot_dirty_r[i];
      slot_age_nxt[i]   = (slot_age_r[i] > sel_age) ? slot_age_r[i] - SLOT_W'(1)
                                                    : slot_age_r[i];
      if (sel_slot == SLOT_W'(i)) begin
        slot_age_nxt[i] = SLOT_W'(SLOTS - 1);
        if (!hit) begin
          slot_block_nxt[i] = b_blk;
          slot_dirty_nxt[i] = b_wr_r;
        end else if (b_wr_r) begin
          slot_dirty_nxt[i] = 1'b1;
        end
      end
    end
  end

  assign evict_xy = lruc_pkg::block_xy(lru_blk);
  assign fill_xy  = lruc_pkg::block_xy(b_blk);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_valid_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_block_r[i] <= BLK_W'(i);
        slot_dirty_r[i] <= 1'b0;
        slot_age_r[i]   <= SLOT_W'(i);
      end
    end else begin
      if (clr_busy) begin
        clr_cnt_r <= clr_cnt_nxt;
      end
      if (in_accept) begin
        b_valid_r <= 1'b1;
      end else if (b_adv) begin
        b_valid_r <= 1'b0;
      end
      if (b_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (b_adv) begin
        for (int i = 0; i < SLOTS; i++) begin
          slot_block_r[i] <= slot_block_nxt[i];
          slot_dirty_r[i] <= slot_dirty_nxt[i];
          slot_age_r[i]   <= slot_age_nxt[i];
        end
        if (!hit) begin
          fwd_valid_r <= 1'b1;
        end
      end
    end
  end

  // Payload registers: hold the access, forward copy and result word.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      b_addr_r <= in_ch.address;
      b_wr_r   <= in_ch.is_write;
    end
    if (b_adv && !hit) begin
      fwd_blk_r <= b_blk;
      fwd_idx_r <= lru_slot;
    end
    if (b_adv) begin
      hit_r        <= hit;
      slot_r       <= 4'(sel_slot);
      offset_r     <= b_addr_r[6:0];
      write_back_r <= !hit && lru_dirty;
      evict_x_r    <= (!hit && lru_dirty) ? evict_xy.x : '0;
      evict_y_r    <= (!hit && lru_dirty) ? evict_xy.y : '0;
      fill_x_r     <= hit ? '0 : fill_xy.x;
      fill_y_r     <= hit ? '0 : fill_xy.y;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = hit_r;
  assign out_ch.slot       = slot_r;
  assign out_ch.offset     = offset_r;
  assign out_ch.write_back = write_back_r;
  assign out_ch.evict_x    = evict_x_r;
  assign out_ch.evict_y    = evict_y_r;
  assign out_ch.fill_x     = fill_x_r;
  assign out_ch.fill_y     = fill_y_r;

endmodule
`default_nettype wire
